[design/fbdp_pkg.sv]
// Package with the shared types and constants of the four-level box downsample pyramid.
`timescale 1ns / 1ps
`default_nettype none

package fbdp_pkg;

    // Number of pyramid levels (2x, 4x, 8x and 16x).
    localparam int NUM_LEVELS = 4;

    // Width of a pixel and of a horizontal pair sum.
    localparam int PIX_W = 8;
    localparam int PAIR_W = PIX_W + 1;

    // Result queue depth and its derived widths.
    localparam int RES_DEPTH = 16;
    localparam int RES_AW = $clog2(RES_DEPTH);
    localparam int NUM_W = $clog2(NUM_LEVELS + 1);

    // The queue accepts a new pixel only while it can absorb a full burst.
    localparam int READY_LIMIT = RES_DEPTH - NUM_LEVELS;

    // Stream data widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // One result item; level sits in the lowest bits.
    typedef struct packed {
        logic                last_of_run;
        logic [PIX_W-1:0]    value;
        logic [2:0]          out_row;
        logic [4:0]          out_col;
        logic [1:0]          level;
    } res_t;

endpackage : fbdp_pkg

`default_nettype wire

[design/four_level_box_downsample_pyramid.sv]
// Top level of the four-level 2x2 box-filter downsampling pyramid.
//
// The block takes the 8-bit luma pixels of one TILE_WIDTH x TILE_HEIGHT tile in
// raster order on s_, one item per clock while s_tvalid and s_tready are high.
// Each item may complete 2x2 blocks at up to four levels (2x, 4x, 8x, 16x), and
// every completed block yields one result item on the m_ channel, in rising
// level order; m_tlast marks the final result caused by one input pixel.
// A result is offered on m_tvalid once its pixel has passed the input register and
// the result has been written into the result queue.
// Throughput: one pixel per cycle while s_tready is high. All levels are worked
// out in one pass between the input register and a 16-entry result queue, which
// takes up to four results per cycle and drains one per cycle. On average far
// fewer than one result is made per pixel, so the queue only throttles s_tready
// when the receiver stalls: a pixel is taken while at most 12 results are
// pending or about to be written.
// Reset (aresetn low, synchronous) clears the column and row counters, the
// input register and the result queue; the next pixel is the first of a tile.
// After the last pixel of a tile both counters wrap and a new tile starts.
// The stored left pixels and even-row pair sums are not cleared: each is always
// written before it is read within a tile.
`timescale 1ns / 1ps
`default_nettype none

module four_level_box_downsample_pyramid
    import fbdp_pkg::*;
#(
    parameter int TILE_WIDTH  = 64,
    parameter int TILE_HEIGHT = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input channel.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [7:0] pixel
    // Result channel.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [1:0] level, [6:2] out_col,
                                                 // [9:7] out_row, [17:10] value
    output logic                      m_tlast    // last_of_run
);

    localparam int CW = $clog2(TILE_WIDTH);
    localparam int RW = $clog2(TILE_HEIGHT);
    localparam logic [CW-1:0] COL_LAST = CW'(TILE_WIDTH - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(TILE_HEIGHT - 1);

    // Position counters of the next source pixel.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Input register holding the pixel being processed.
    logic             stg_valid_reg;
    logic [PIX_W-1:0] stg_pix_reg;
    logic [CW-1:0]    stg_col_reg;
    logic [RW-1:0]    stg_row_reg;

    // Per-level results of the pass over the staged pixel.
    logic [NUM_LEVELS-1:0] emit;
    logic [PIX_W-1:0]      val_w [0:NUM_LEVELS-1];
    res_t                  res_w [0:NUM_LEVELS-1];
    logic [NUM_W-1:0]      n_emit;

    // Result queue.
    res_t              fifo_mem [0:RES_DEPTH-1];
    logic [RES_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_AW:0]   cnt_reg, cnt_next;
    logic [RES_AW+1:0] room_sum;

    logic s_fire;
    logic m_fire;
    res_t head;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // ------------------------------------------------------------------
    // Position counters: raster order with wrap at the end of the tile.
    // ------------------------------------------------------------------
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (col_reg == COL_LAST) begin
                col_next = '0;
                row_next = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            stg_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stg_pix_reg <= s_tdata[PIX_W-1:0];
            stg_col_reg <= col_reg;
            stg_row_reg <= row_reg;
        end
    end

    // ------------------------------------------------------------------
    // One slice per level. A level sees the staged pixel (level 0) or the
    // result of the level below, at the position shifted down by the level.
    // ------------------------------------------------------------------
    for (genvar L = 0; L < NUM_LEVELS; L++) begin : g_lvl
        localparam int DEPTH = TILE_WIDTH >> (L + 1);
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
        // A trailing odd column or row has no partner.
        localparam logic [CW:0] COL_LIM = (CW + 1)'(((TILE_WIDTH >> L) / 2) * 2);
        localparam logic [RW:0] ROW_LIM = (RW + 1)'(((TILE_HEIGHT >> L) / 2) * 2);

        logic [PAIR_W-1:0] sum_mem [0:(2**AW)-1];
        logic [PAIR_W-1:0] rd_sum_reg;
        logic [PIX_W-1:0]  left_reg;

        logic [CW-1:0]     cl, ci, rd_col;
        logic [RW-1:0]     rl, ri;
        logic [AW-1:0]     rd_addr, wr_addr;
        logic              reach, go, wr_left, wr_sum;
        logic [PIX_W-1:0]  pix_in;
        logic [PAIR_W-1:0] hsum;
        logic [PAIR_W:0]   total;

        if (L == 0) begin : g_first
            assign reach  = stg_valid_reg;
            assign pix_in = stg_pix_reg;
        end else begin : g_upper
            assign reach  = emit[L-1];
            assign pix_in = val_w[L-1];
        end

        assign cl = stg_col_reg >> L;
        assign rl = stg_row_reg >> L;
        assign ci = stg_col_reg >> (L + 1);
        assign ri = stg_row_reg >> (L + 1);

        // The pair sum for this level is read when the pixel is accepted, so
        // it is ready in the register stage alongside the pixel.
        assign rd_col  = col_reg >> (L + 1);
        assign rd_addr = rd_col[AW-1:0];
        assign wr_addr = ci[AW-1:0];

        assign go      = reach && ({1'b0, cl} < COL_LIM) && ({1'b0, rl} < ROW_LIM);
        assign wr_left = go && !cl[0];
        assign wr_sum  = go && cl[0] && !rl[0];
        assign emit[L] = go && cl[0] && rl[0];

        assign hsum     = {1'b0, left_reg} + {1'b0, pix_in};
        assign total    = {1'b0, rd_sum_reg} + {1'b0, hsum} + (PAIR_W + 1)'(2);
        assign val_w[L] = total[PAIR_W:2];

        always_ff @(posedge aclk) begin
            if (s_fire) begin
                rd_sum_reg <= sum_mem[rd_addr];
            end
            if (wr_sum) begin
                sum_mem[wr_addr] <= hsum;
            end
        end

        always_ff @(posedge aclk) begin
            if (wr_left) begin
                left_reg <= pix_in;
            end
        end

        assign res_w[L].level   = 2'(L);
        assign res_w[L].out_col = 5'(ci);
        assign res_w[L].out_row = 3'(ri);
        assign res_w[L].value   = val_w[L];
        if (L == NUM_LEVELS - 1) begin : g_top_last
            assign res_w[L].last_of_run = emit[L];
        end else begin : g_mid_last
            assign res_w[L].last_of_run = emit[L] && !emit[L+1];
        end
    end

    // Results always come as a prefix of the levels, so the count places them.
    always_comb begin
        n_emit = '0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            n_emit = n_emit + NUM_W'(emit[k]);
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to four writes per cycle, one read per cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (emit[k]) begin
                fifo_mem[wr_ptr_reg + RES_AW'(k)] <= res_w[k];
            end
        end
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_AW'(n_emit);
        rd_ptr_next = m_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (RES_AW + 1)'(n_emit) - (RES_AW + 1)'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Space for the results in flight plus a full burst of the next pixel.
    assign room_sum = (RES_AW + 2)'(cnt_reg) + (RES_AW + 2)'(n_emit);
    assign s_tready = (room_sum <= (RES_AW + 2)'(READY_LIMIT));

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {6'b0, head.value, head.out_row, head.out_col, head.level};
    assign m_tlast  = head.last_of_run;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The queue never holds more than its depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (RES_AW + 1)'(RES_DEPTH))
        else $error("result queue overflow");

    // A higher level only fires when every level below it fired.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(emit[1] && !emit[0]) && !(emit[2] && !emit[1]) && !(emit[3] && !emit[2]))
        else $error("level results are not a prefix");

    // Results appear only for a staged pixel and the queue has room for them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (n_emit != '0) |-> (stg_valid_reg && (room_sum <= (RES_AW + 2)'(RES_DEPTH))))
        else $error("results written without room or without a pixel");

    // An accepted pixel is in the input register in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> stg_valid_reg)
        else $error("accepted pixel lost");

endmodule : four_level_box_downsample_pyramid

`default_nettype wire

[test/four_level_box_downsample_pyramid_checker.sv]
// Checker that predicts the pyramid's result items from the accepted pixels and compares them.
`timescale 1ns / 1ps

module four_level_box_downsample_pyramid_checker
    import fbdp_pkg::*;
#(
    parameter int TILE_WIDTH  = 64,
    parameter int TILE_HEIGHT = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   pending,
    output int                   fail_count
);

    localparam int RES_W = $bits(res_t);

    // Downsampled pixels predicted but not yet seen on the result channel.
    res_t queued_downsamples[$];

    // Predictor state: position of the next source pixel, the even-column pixel of each
    // level's pair under construction, and each level's even-row pair sums.
    int                col_pos;
    int                row_pos;
    logic [PIX_W-1:0]  left_pixel [NUM_LEVELS];
    logic [PAIR_W-1:0] even_row_sum [NUM_LEVELS][TILE_WIDTH/2];
    int                mismatches;

    initial begin
        pending    = 0;
        fail_count = 0;
        mismatches = 0;
    end

    // Feeds one source pixel through all levels and queues the blocks it completes.
    task automatic downsample_pixel(input logic [PIX_W-1:0] px);
        res_t              burst [NUM_LEVELS];
        int                n_res;
        int                c;
        int                r;
        int                idx;
        logic [PIX_W-1:0]  p;
        logic [PAIR_W-1:0] hsum;
        logic [PAIR_W+1:0] total;
        bit                done;
        n_res = 0;
        c     = col_pos;
        r     = row_pos;
        p     = px;
        done  = 1'b0;
        for (int lvl = 0; lvl < NUM_LEVELS && !done; lvl++) begin
            idx = c >> 1;
            if (c >= (TILE_WIDTH >> lvl) / 2 * 2 || r >= (TILE_HEIGHT >> lvl) / 2 * 2) begin
                // A trailing column or row without a partner stops here.
                done = 1'b1;
            end else if (c % 2 == 0) begin
                left_pixel[lvl] = p;
                done = 1'b1;
            end else if (idx >= (TILE_WIDTH >> (lvl + 1))) begin
                done = 1'b1;
            end else begin
                hsum = left_pixel[lvl] + p;
                if (r % 2 == 0) begin
                    even_row_sum[lvl][idx] = hsum;
                    done = 1'b1;
                end else begin
                    total = (PAIR_W + 2)'(even_row_sum[lvl][idx] + hsum + 2);
                    burst[n_res].level       = 2'(lvl);
                    burst[n_res].out_col     = 5'(idx);
                    burst[n_res].out_row     = 3'(r >> 1);
                    burst[n_res].value       = total[PIX_W+1:2];
                    burst[n_res].last_of_run = 1'b0;
                    p = total[PIX_W+1:2];
                    c = idx;
                    r = r >> 1;
                    n_res++;
                end
            end
        end
        if (n_res > 0) begin
            burst[n_res-1].last_of_run = 1'b1;
        end
        for (int k = 0; k < n_res; k++) begin
            queued_downsamples.push_back(burst[k]);
        end
        col_pos++;
        if (col_pos >= TILE_WIDTH) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= TILE_HEIGHT) begin
                row_pos = 0;
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            queued_downsamples.delete();
            col_pos = 0;
            row_pos = 0;
            for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
                left_pixel[lvl] = '0;
                for (int i = 0; i < TILE_WIDTH / 2; i++) begin
                    even_row_sum[lvl][i] = '0;
                end
            end
        end else begin
            // Results first: a pixel accepted at this edge cannot have a result out yet.
            if (m_tvalid && m_tready) begin
                got = res_t'({m_tlast, m_tdata[RES_W-2:0]});
                if (queued_downsamples.size() == 0) begin
                    $display("%0t ns: no result expected, actual level %0d col %0d row %0d value %0d last %0d",
                             $time, got.level, got.out_col, got.out_row, got.value,
                             got.last_of_run);
                    mismatches++;
                end else begin
                    want = queued_downsamples.pop_front();
                    check_field("level", want.level, got.level);
                    check_field("out_col", want.out_col, got.out_col);
                    check_field("out_row", want.out_row, got.out_row);
                    check_field("value", want.value, got.value);
                    check_field("last_of_run", want.last_of_run, got.last_of_run);
                    check_field("tdata padding", 0, m_tdata[M_TDATA_W-1:RES_W-1]);
                end
            end
            if (s_tvalid && s_tready) begin
                downsample_pixel(s_tdata);
            end
        end
        pending    <= queued_downsamples.size();
        fail_count <= mismatches;
    end

endmodule

[test/four_level_box_downsample_pyramid_tb.sv]
// Testbench top for the four-level box downsample pyramid: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module four_level_box_downsample_pyramid_tb;
    import fbdp_pkg::*;

    localparam int TILE_WIDTH  = 64;
    localparam int TILE_HEIGHT = 16;
    localparam int TILE_PIXELS = TILE_WIDTH * TILE_HEIGHT;

    // The run covers the first five rows of a tile and a few pixels more. Rows one and three and
    // the start of row five bring 2x results, row three also brings 4x results, each with chains of two results.
    localparam int DIRECTED_PIXELS = 25;
    localparam int TOTAL_PIXELS    = 5 * TILE_WIDTH + 10;

    // The sender holds off until every predicted result has drained at these items.
    localparam int QUIET_FIRST  = 300;
    localparam int QUIET_SECOND = 2 * TILE_WIDTH;

    // Time for the input register plus up to four queued results, with a margin on top.
    localparam int DRAIN_CYCLES = 12;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire                  m_tlast;
    int                   pending;
    int                   fail_count;

    // Flat value of each 16-column region during rows two and three. Flat regions drive the
    // 2x level to the same value, so the extremes 0 and 255 appear as results.
    logic [7:0] region_level [4];

    // Opening pixels of the first row: the extremes, alternating extremes, walking ones and
    // walking zeros, so every bit of the pixel is seen at both values early on.
    logic [7:0] directed_px [DIRECTED_PIXELS] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
        8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
        8'h55, 8'hAA, 8'h80, 8'h7F, 8'h01
    };

    four_level_box_downsample_pyramid #(
        .TILE_WIDTH (TILE_WIDTH),
        .TILE_HEIGHT(TILE_HEIGHT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    four_level_box_downsample_pyramid_checker #(
        .TILE_WIDTH (TILE_WIDTH),
        .TILE_HEIGHT(TILE_HEIGHT)
    ) pyramid_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .pending   (pending),
        .fail_count(fail_count)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle length for either side: mostly none, often a few cycles, sometimes a long gap.
    function automatic int idle_cycles();
        int roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Pixel for item n of the stream. Rows two and three are made of flat regions; the other
    // rows are random with the two extremes weighted up, which exercises rounding and carries.
    function automatic logic [7:0] next_pixel(input int n);
        int col;
        col = (n % TILE_PIXELS) % TILE_WIDTH;
        if (n < DIRECTED_PIXELS) begin
            return directed_px[n];
        end
        if ((n % TILE_PIXELS) / (2 * TILE_WIDTH) == 1) begin
            return region_level[col / (TILE_WIDTH / 4)];
        end
        case ($urandom_range(0, 3))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // Pixel source. Every pixel position is a legal one, so the whole stream is well formed;
    // the randomness lies in the values and in the gaps between items.
    initial begin
        int gap;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        for (int n = 0; n < TOTAL_PIXELS; n++) begin
            // Every third stretch of 100 items runs back to back with no gaps.
            gap = ((n / 100) % 3 == 1) ? 0 : idle_cycles();
            if (n == 2 * TILE_WIDTH) begin
                region_level[0] = 8'hFF;
                region_level[1] = 8'h00;
                region_level[2] = 8'($urandom);
                region_level[3] = 8'($urandom);
            end
            if (gap > 0 || n == QUIET_FIRST || n == QUIET_SECOND) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                if (n == QUIET_FIRST || n == QUIET_SECOND) begin
                    // Let the block drain completely before going on.
                    do @(posedge aclk); while (pending != 0);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= next_pixel(n);
            do @(posedge aclk); while (s_tready !== 1'b1);
        end
        s_tvalid <= 1'b0;

        // Wait for the last results, then give stray results a chance to show up.
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result sink: open for a random run of cycles, now and then for a long stretch, then
    // stalled for a random gap. Stalls back the result queue up and so throttle s_tready.
    initial begin
        int stall;
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if ($urandom_range(0, 9) == 0) begin
                repeat (200) @(posedge aclk);
            end
            stall = idle_cycles();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Watchdog. A correct run with the longest gaps on both sides ends well before 4 ms of
    // simulated time, so reaching it means the block has hung.
    initial begin
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
